// ===== design/pip_pkg.sv =====
`timescale 1ns / 1ps

package pip_pkg;

	localparam int LAT_W  = 31;
	localparam int LON_W  = 32;
	localparam int SCL_W  = 17;
	localparam int IDX_W  = 16;
	localparam int XW     = LON_W + SCL_W;
	localparam int DW     = XW + 1;
	localparam int HALF_W = 25;
	localparam int PP_W   = 2 * (DW - HALF_W + 1);
	localparam int VTX_W  = LAT_W + LON_W;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_QUERY = 2'd1,
		FUNC_EDGE  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_RDB   = 10'b0000000010,
		S_LATB  = 10'b0000000100,
		S_PROJ  = 10'b0000001000,
		S_DIFF  = 10'b0000010000,
		S_MAC   = 10'b0000100000,
		S_DRAIN = 10'b0001000000,
		S_EVAL  = 10'b0010000000,
		S_OUT   = 10'b0100000000,
		S_SPARE = 10'b1000000000
	} state_t;

endpackage

// ===== design/point_in_polygon_test_core.sv =====
// A tested edge occupies the core from its acceptance through two vertex reads, three
//   projections, 24 partial products through one 26x26 multiplier and evaluation.
// Loads, queries and skipped edges are taken while idle; a tested edge holds off new input
//   until evaluated; an edge marked last then waits in S_OUT to hand its result to the output register.
// The result of a last edge is loaded from S_OUT once the output register is free.
// Reset clears control state, query latches and flags; the vertex store is not cleared.
`timescale 1ns / 1ps

module point_in_polygon_test_core
	import pip_pkg::*;
#(
	parameter int VERTEX_DEPTH    = 1024,
	parameter int SCALE_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// index[15:0], lat[46:16], lon[78:47], lon_scale[95:79]
	input  logic [95:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// inside_res[0], on_boundary[1]
	output logic [7:0]  m_axis_tdata
);

	localparam int AW    = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int ACC_W = 2 * DW + 2 * SCALE_FRAC_BITS + 2;

	logic [9:0]  ring_base_q;
	logic [10:0] ring_size_q;

	logic [IDX_W-1:0]        in_idx;
	logic signed [LAT_W-1:0] in_lat;
	logic signed [LON_W-1:0] in_lon;
	logic [SCL_W-1:0]        in_scl;
	func_t                   in_func;
	logic                    acc_in;

	assign in_idx  = s_axis_tdata[15:0];
	assign in_lat  = s_axis_tdata[46:16];
	assign in_lon  = s_axis_tdata[78:47];
	assign in_scl  = s_axis_tdata[95:79];
	assign in_func = func_t'(s_axis_tuser);
	assign acc_in  = s_axis_tvalid && s_axis_tready;

	state_t state_q;

	logic signed [LAT_W-1:0] qlat_q;
	logic signed [LON_W-1:0] qlon_q;
	logic [SCL_W-1:0]        qscl_q;
	logic                    par_q;
	logic                    hit_q;
	logic                    last_q;
	logic [AW-1:0]           ib_q;

	logic [VTX_W-1:0]        vmem [VERTEX_DEPTH];
	logic [VTX_W-1:0]        rd_q;
	logic [AW-1:0]           rd_addr;

	logic signed [LAT_W-1:0] alat_q, blat_q;
	logic signed [LON_W-1:0] alon_q, blon_q;
	logic signed [XW-1:0]    ax_q, bx_q, px_q;
	logic [1:0]              pcnt_q;
	logic signed [DW-1:0]    dx_q, rx_q;
	logic signed [LAT_W:0]   dy_q, ry_q;
	logic [4:0]              mcnt_q;

	logic signed [ACC_W-1:0] cross_q, dot_q, len_q;
	logic signed [PP_W-1:0]  pp_s1;
	logic [6:0]              sh_s1;
	logic                    neg_s1;
	logic [1:0]              dst_s1;
	logic                    v_s1;

	logic       res_in_q, res_on_q;
	logic       mval_q;

	// ring validity and addresses
	logic        ring_ok;
	logic [17:0] base18, size18, depth18;
	logic        idx_in;
	logic [IDX_W-1:0] prev_idx;
	logic [17:0] ia18, ib18;
	logic        tested;

	assign base18  = 18'(ring_base_q);
	assign size18  = 18'(ring_size_q);
	assign depth18 = 18'(VERTEX_DEPTH);
	assign ring_ok = (ring_size_q >= 11'd4) && (base18 < depth18) &&
		(base18 + size18 <= depth18);
	assign idx_in   = 18'(in_idx) < size18;
	assign prev_idx = (in_idx == '0) ? (16'(ring_size_q) - 16'd1) : (in_idx - 16'd1);
	assign ia18     = base18 + 18'(in_idx);
	assign ib18     = base18 + 18'(prev_idx);
	assign tested   = ring_ok && idx_in && !hit_q;

	assign s_axis_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_base_q <= '0;
			ring_size_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) begin
				ring_base_q <= cfg_data[9:0];
			end else begin
				ring_size_q <= cfg_data;
			end
		end
	end

	// vertex store
	assign rd_addr = (state_q == S_RDB) ? ib_q : ia18[AW-1:0];

	always_ff @(posedge clk) begin
		if (acc_in && in_func == FUNC_LOAD && 17'(in_idx) < 17'(VERTEX_DEPTH)) begin
			vmem[in_idx[AW-1:0]] <= {in_lat, in_lon};
		end
		rd_q <= vmem[rd_addr];
	end

	// projection multiplier
	logic signed [LON_W-1:0] proj_lon;
	logic signed [XW-1:0]    proj_x;

	always_comb begin
		case (pcnt_q)
			2'd0:    proj_lon = alon_q;
			2'd1:    proj_lon = blon_q;
			default: proj_lon = qlon_q;
		endcase
	end
	assign proj_x = XW'(proj_lon * $signed({1'b0, qscl_q}));

	// partial product operands
	logic [2:0]              term;
	logic [1:0]              part;
	logic signed [DW-1:0]    op_a, op_b;
	logic signed [HALF_W:0]  pa, pb;
	logic [6:0]              sh_n;

	assign term = mcnt_q[4:2];
	assign part = mcnt_q[1:0];

	always_comb begin
		case (term)
			3'd0:    begin op_a = rx_q; op_b = DW'(dy_q); end
			3'd1:    begin op_a = DW'(ry_q); op_b = dx_q; end
			3'd2:    begin op_a = rx_q; op_b = dx_q; end
			3'd3:    begin op_a = DW'(ry_q); op_b = DW'(dy_q); end
			3'd4:    begin op_a = dx_q; op_b = dx_q; end
			default: begin op_a = DW'(dy_q); op_b = DW'(dy_q); end
		endcase
		pa = part[1] ? (HALF_W + 1)'($signed(op_a[DW-1:HALF_W])) :
			$signed({1'b0, op_a[HALF_W-1:0]});
		pb = part[0] ? (HALF_W + 1)'($signed(op_b[DW-1:HALF_W])) :
			$signed({1'b0, op_b[HALF_W-1:0]});
		sh_n = 7'((32'(part[1]) + 32'(part[0])) * HALF_W);
		if (term == 3'd3 || term == 3'd5) begin
			sh_n = sh_n + 7'(2 * SCALE_FRAC_BITS);
		end
	end

	logic signed [ACC_W-1:0] addend;
	assign addend = ACC_W'(pp_s1) <<< sh_s1;

	// evaluation
	logic signed [ACC_W-1:0] tol;
	logic near, dot_ok, degen, straddle, cross_dir;
	logic hit_n, par_n;

	assign tol       = ACC_W'(1) <<< SCALE_FRAC_BITS;
	assign near      = (cross_q <= tol) && (cross_q >= -tol);
	assign dot_ok    = !dot_q[ACC_W-1] && (dot_q <= len_q);
	assign degen     = (dx_q == '0) && (dy_q == '0);
	assign straddle  = (alat_q > qlat_q) != (blat_q > qlat_q);
	assign cross_dir = (dy_q > 0) ? (cross_q <= 0) : (cross_q >= 0);

	always_comb begin
		hit_n = hit_q;
		par_n = par_q;
		if (degen) begin
			if (rx_q == '0 && ry_q == '0) begin
				hit_n = 1'b1;
			end
		end else if (near && dot_ok) begin
			hit_n = 1'b1;
		end else if (straddle && cross_dir) begin
			par_n = !par_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			qlat_q   <= '0;
			qlon_q   <= '0;
			qscl_q   <= '0;
			par_q    <= 1'b0;
			hit_q    <= 1'b0;
			last_q   <= 1'b0;
			pcnt_q   <= '0;
			mcnt_q   <= '0;
			v_s1     <= 1'b0;
			mval_q   <= 1'b0;
		end else begin
			if (mval_q && m_axis_tready && state_q != S_OUT) begin
				mval_q <= 1'b0;
			end
			v_s1 <= (state_q == S_MAC);
			case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						case (in_func)
							FUNC_QUERY: begin
								qlat_q <= in_lat;
								qlon_q <= in_lon;
								qscl_q <= in_scl;
								par_q  <= 1'b0;
								hit_q  <= 1'b0;
							end
							FUNC_EDGE: begin
								last_q <= s_axis_tlast;
								if (tested) begin
									state_q <= S_RDB;
								end else if (s_axis_tlast) begin
									state_q <= S_OUT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RDB:  state_q <= S_LATB;
				S_LATB: begin
					pcnt_q  <= '0;
					state_q <= S_PROJ;
				end
				S_PROJ: begin
					pcnt_q <= pcnt_q + 2'd1;
					if (pcnt_q == 2'd2) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					mcnt_q  <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					mcnt_q <= mcnt_q + 5'd1;
					if (mcnt_q == 5'd23) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_EVAL;
				S_EVAL: begin
					hit_q   <= hit_n;
					par_q   <= par_n;
					state_q <= last_q ? S_OUT : S_IDLE;
				end
				S_OUT: begin
					if (!mval_q || m_axis_tready) begin
						mval_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			ib_q <= ib18[AW-1:0];
		end
		if (state_q == S_RDB) begin
			alat_q <= rd_q[VTX_W-1:LON_W];
			alon_q <= rd_q[LON_W-1:0];
		end
		if (state_q == S_LATB) begin
			blat_q <= rd_q[VTX_W-1:LON_W];
			blon_q <= rd_q[LON_W-1:0];
		end
		if (state_q == S_PROJ) begin
			case (pcnt_q)
				2'd0:    ax_q <= proj_x;
				2'd1:    bx_q <= proj_x;
				default: px_q <= proj_x;
			endcase
		end
		if (state_q == S_DIFF) begin
			dx_q    <= DW'(bx_q) - DW'(ax_q);
			rx_q    <= DW'(px_q) - DW'(ax_q);
			dy_q    <= (LAT_W + 1)'(blat_q) - (LAT_W + 1)'(alat_q);
			ry_q    <= (LAT_W + 1)'(qlat_q) - (LAT_W + 1)'(alat_q);
			cross_q <= '0;
			dot_q   <= '0;
			len_q   <= '0;
		end
		pp_s1  <= pa * pb;
		sh_s1  <= sh_n;
		neg_s1 <= (term == 3'd1);
		dst_s1 <= 2'(term >> 1);
		if (v_s1) begin
			case (dst_s1)
				2'd0:    cross_q <= neg_s1 ? cross_q - addend : cross_q + addend;
				2'd1:    dot_q   <= dot_q + addend;
				default: len_q   <= len_q + addend;
			endcase
		end
		if (state_q == S_OUT && (!mval_q || m_axis_tready)) begin
			res_in_q <= ring_ok && (hit_q || par_q);
			res_on_q <= ring_ok && hit_q;
		end
	end

	assign m_axis_tvalid = mval_q;
	assign m_axis_tdata  = {6'd0, res_on_q, res_in_q};

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (!mval_q || m_axis_tready)) |=> mval_q)
		else $error("result not presented");

	a_hit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(hit_q) |-> $past(acc_in && in_func == FUNC_QUERY))
		else $error("boundary flag cleared without query");

	a_par_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(par_q) |-> $past(state_q == S_EVAL || (acc_in && in_func == FUNC_QUERY)))
		else $error("parity changed outside evaluation");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> ($past(state_q == S_MAC) && v_s1))
		else $error("accumulate drain out of order");

endmodule
